@@ rtl/dense_to_adjacency_list_defines.svh @@
// ----------------------------------------------------------------------------
// dense_to_adjacency_list_defines
// Assertion macros shared by the checker of the adjacency list builder.
// ----------------------------------------------------------------------------
`ifndef DENSE_TO_ADJACENCY_LIST_DEFINES_SVH
`define DENSE_TO_ADJACENCY_LIST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define D2AL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define D2AL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset as well
`define D2AL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/d2al_pkg.sv @@
// ----------------------------------------------------------------------------
// d2al_pkg
// Shared widths, reset values, register indexes and types of the builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package d2al_pkg;

   // default sizes of the graph
   localparam int NODES_DEF          = 64;
   localparam int MAX_NEIGHBOURS_DEF = 16;

   // field widths
   localparam int WEIGHT_W     = 17;
   localparam int NODE_COUNT_W = 7;
   localparam int NODE_W       = 6;
   localparam int SLOT_W       = 4;

   // register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT = 1'd1;

   localparam logic [WEIGHT_W-1:0]     THRESHOLD_RESET  = 17'd1;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // control of the neighbour count store
   typedef struct packed {
      logic wr_en;
      logic clear;
      logic rd_en;
   } cnt_ctl_type;

endpackage

`default_nettype wire

@@ rtl/dense_to_adjacency_list.sv @@
// ----------------------------------------------------------------------------
// dense_to_adjacency_list
// Turns a row-major stream of adjacency weights into neighbour list appends.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one matrix weight per item, row-major; the flag
//    req_first_of_matrix restarts at element (0,0) and clears all counts.
//  - rsp_ channel carries one list append (node, slot, neighbour) per item,
//    or a single overflow item when a list has no room; rsp_last marks the
//    final result of an input.
//  - csr_ port writes threshold (index 0) and node_count (index 1); the user
//    must do so only while the block is idle, the block does not enforce it.
// Flow:
//  - an accepted input is registered in the stage register; its first result
//    is then registered in the output register.
//  - an input with no connection gives no result, an overflow one result and
//    a connection two, passed one at a time through the single output
//    register and the single write port of the count store.
// Reset clears position, counts, registers and any pending result.
// When rsp_ready is low the result holds in the output register and the
// stage register stops taking inputs once it holds an item with results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dense_to_adjacency_list #(
   parameter int NODES          = d2al_pkg::NODES_DEF,
   parameter int MAX_NEIGHBOURS = d2al_pkg::MAX_NEIGHBOURS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [d2al_pkg::WEIGHT_W-1:0]    req_weight,
   input  logic                             req_first_of_matrix,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [d2al_pkg::NODE_W-1:0]      rsp_node,
   output logic [d2al_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [d2al_pkg::NODE_W-1:0]      rsp_neighbour,
   output logic                             rsp_overflow,
   output logic                             rsp_last,
   // register writes
   input  logic                             csr_write_enable,
   input  logic [d2al_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [d2al_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import d2al_pkg::*;

   localparam int PW = $clog2(NODES);
   localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

   // configuration registers
   logic [WEIGHT_W-1:0]     threshold_ff, threshold_in;
   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;

   // stage register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_phase_ff, s1_phase_in;
   logic                s1_first_ff, s1_first_in;
   logic [PW-1:0]       s1_row_ff, s1_row_in;
   logic [PW-1:0]       s1_col_ff, s1_col_in;
   logic [WEIGHT_W-1:0] s1_weight_ff, s1_weight_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [NODE_W-1:0] rsp_neighbour_ff, rsp_neighbour_in;
   logic              rsp_overflow_ff, rsp_overflow_in;
   logic              rsp_last_ff, rsp_last_in;

   logic          accept;
   logic [PW-1:0] cur_row, cur_col;
   logic [CW-1:0] rd_col_cnt, rd_row_cnt;
   logic [CW-1:0] cr, cc;
   logic [CW:0]   cr_plus2, max_c;
   logic          diag, hit, fits, two_res, emit, out_free, load_out, s1_done;
   cnt_ctl_type   cnt_ctl;
   logic [PW-1:0] wr_addr;
   logic [CW-1:0] wr_data;

   // register writes
   always_comb begin
      threshold_in  = threshold_ff;
      node_count_in = node_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_THRESHOLD: begin
               threshold_in = csr_write_data[WEIGHT_W-1:0];
            end
            CSR_NODE_COUNT: begin
               node_count_in = csr_write_data[NODE_COUNT_W-1:0];
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         node_count_ff <= node_count_in;
      end
   end

   // position of the next item
   d2al_position #(
      .NODES (NODES)
   ) u_position (
      .clock           (clock),
      .reset           (reset),
      .step            (accept),
      .first_of_matrix (req_first_of_matrix),
      .node_count      (node_count_ff),
      .cur_row         (cur_row),
      .cur_col         (cur_col)
   );

   // neighbour counts, read when an item is accepted
   d2al_counts #(
      .NODES          (NODES),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
   ) u_counts (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cnt_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (cur_col),
      .rd_addr_b (cur_row),
      .rd_data_a (rd_col_cnt),
      .rd_data_b (rd_row_cnt)
   );

   // connection test and room check
   always_comb begin
      cr       = s1_first_ff ? '0 : rd_row_cnt;
      cc       = s1_first_ff ? '0 : rd_col_cnt;
      cr_plus2 = {1'b0, cr} + (CW+1)'(2);
      max_c    = (CW+1)'(MAX_NEIGHBOURS);
      diag     = (s1_col_ff == s1_row_ff);
      hit      = (s1_weight_ff >= threshold_ff) && (s1_col_ff <= s1_row_ff);
      if (diag) begin
         fits = (cr_plus2 <= max_c);
      end else begin
         fits = ({1'b0, cr} < max_c) && ({1'b0, cc} < max_c);
      end
      two_res  = hit && fits;
      emit     = s1_valid_ff && hit;
      out_free = !rsp_valid_ff || rsp_ready;
      load_out = emit && out_free;
      s1_done  = s1_valid_ff && (!hit || (out_free && (!two_res || s1_phase_ff)));
   end

   assign req_ready = !s1_valid_ff || s1_done;
   assign accept    = req_valid && req_ready;

   // result selection and count update
   always_comb begin
      rsp_node_in      = rsp_node_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_neighbour_in = rsp_neighbour_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (!two_res) begin
            rsp_node_in      = '0;
            rsp_slot_in      = '0;
            rsp_neighbour_in = '0;
            rsp_overflow_in  = 1'b1;
            rsp_last_in      = 1'b1;
         end else if (!s1_phase_ff) begin
            rsp_node_in      = diag ? NODE_W'(s1_row_ff) : NODE_W'(s1_col_ff);
            rsp_slot_in      = diag ? SLOT_W'(cr) : SLOT_W'(cc);
            rsp_neighbour_in = NODE_W'(s1_row_ff);
            rsp_overflow_in  = 1'b0;
            rsp_last_in      = 1'b0;
         end else begin
            rsp_node_in      = NODE_W'(s1_row_ff);
            rsp_slot_in      = diag ? SLOT_W'(cr + CW'(1)) : SLOT_W'(cr);
            rsp_neighbour_in = diag ? NODE_W'(s1_row_ff) : NODE_W'(s1_col_ff);
            rsp_overflow_in  = 1'b0;
            rsp_last_in      = 1'b1;
         end
      end

      // column list grows with the first result, row list with the second;
      // a self loop adds both slots at once
      cnt_ctl.rd_en = accept;
      cnt_ctl.clear = s1_valid_ff && s1_first_ff && !s1_phase_ff;
      cnt_ctl.wr_en = load_out && two_res && !(s1_phase_ff && diag);
      wr_addr       = (!s1_phase_ff && !diag) ? s1_col_ff : s1_row_ff;
      if (!s1_phase_ff) begin
         wr_data = diag ? CW'(cr_plus2) : cc + CW'(1);
      end else begin
         wr_data = cr + CW'(1);
      end
   end

   // stage register
   always_comb begin
      s1_valid_in  = s1_valid_ff && !s1_done;
      s1_first_in  = s1_first_ff;
      s1_row_in    = s1_row_ff;
      s1_col_in    = s1_col_ff;
      s1_weight_in = s1_weight_ff;
      if (s1_done) begin
         s1_phase_in = 1'b0;
      end else if (load_out && two_res) begin
         s1_phase_in = 1'b1;
      end else begin
         s1_phase_in = s1_phase_ff;
      end
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_first_in  = req_first_of_matrix;
         s1_row_in    = cur_row;
         s1_col_in    = cur_col;
         s1_weight_in = req_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff      <= s1_first_in;
      s1_row_ff        <= s1_row_in;
      s1_col_ff        <= s1_col_in;
      s1_weight_ff     <= s1_weight_in;
      rsp_node_ff      <= rsp_node_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_neighbour_ff <= rsp_neighbour_in;
      rsp_overflow_ff  <= rsp_overflow_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_node      = rsp_node_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_neighbour = rsp_neighbour_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/d2al_counts.sv @@
// ----------------------------------------------------------------------------
// d2al_counts
// Neighbour count store: one write port, two registered read ports, with a
// valid bit per node so that a matrix start clears all counts at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module d2al_counts #(
   parameter int NODES          = d2al_pkg::NODES_DEF,
   parameter int MAX_NEIGHBOURS = d2al_pkg::MAX_NEIGHBOURS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  d2al_pkg::cnt_ctl_type                    ctl,
   input  logic [$clog2(NODES)-1:0]                 wr_addr,
   input  logic [$clog2(MAX_NEIGHBOURS+1)-1:0]      wr_data,
   input  logic [$clog2(NODES)-1:0]                 rd_addr_a,
   input  logic [$clog2(NODES)-1:0]                 rd_addr_b,
   output logic [$clog2(MAX_NEIGHBOURS+1)-1:0]      rd_data_a,
   output logic [$clog2(MAX_NEIGHBOURS+1)-1:0]      rd_data_b
);
   import d2al_pkg::*;

   localparam int AW = $clog2(NODES);
   localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

   logic [CW-1:0]    count_mem [NODES];
   logic [NODES-1:0] valid_ff, valid_in;
   logic [CW-1:0]    a_data_ff, b_data_ff;
   logic             a_live_ff, a_live_in;
   logic             b_live_ff, b_live_in;
   logic             hit_a, hit_b;

   // valid bits: cleared together on a matrix start, set on each write
   always_comb begin
      valid_in = ctl.clear ? '0 : valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // read-during-write returns the new value
   assign hit_a = ctl.wr_en && (wr_addr == rd_addr_a);
   assign hit_b = ctl.wr_en && (wr_addr == rd_addr_b);

   always_comb begin
      a_live_in = a_live_ff;
      b_live_in = b_live_ff;
      if (ctl.rd_en) begin
         a_live_in = hit_a || (!ctl.clear && valid_ff[rd_addr_a]);
         b_live_in = hit_b || (!ctl.clear && valid_ff[rd_addr_b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         a_live_ff <= 1'b0;
         b_live_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         a_live_ff <= a_live_in;
         b_live_ff <= b_live_in;
      end
   end

   // count array and registered reads
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         a_data_ff <= hit_a ? wr_data : count_mem[rd_addr_a];
         b_data_ff <= hit_b ? wr_data : count_mem[rd_addr_b];
      end
   end

   // an entry never written since the last clear reads as zero
   assign rd_data_a = a_live_ff ? a_data_ff : '0;
   assign rd_data_b = b_live_ff ? b_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/d2al_position.sv @@
// ----------------------------------------------------------------------------
// d2al_position
// Row and column tracker of the incoming matrix stream, row-major order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module d2al_position #(
   parameter int NODES = d2al_pkg::NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              first_of_matrix,
   input  logic [d2al_pkg::NODE_COUNT_W-1:0] node_count,
   output logic [$clog2(NODES)-1:0]          cur_row,
   output logic [$clog2(NODES)-1:0]          cur_col
);
   import d2al_pkg::*;

   localparam int PW    = $clog2(NODES);
   localparam int CMP_W = (NODE_COUNT_W > PW + 1) ? NODE_COUNT_W : PW + 1;

   logic [PW-1:0]    row_ff, row_in;
   logic [PW-1:0]    col_ff, col_in;
   logic [CMP_W-1:0] nc_wide, used_n;

   // position of the item at the port; a matrix start is element (0,0)
   assign cur_row = first_of_matrix ? '0 : row_ff;
   assign cur_col = first_of_matrix ? '0 : col_ff;

   // nodes in use, clamped to 1..NODES
   always_comb begin
      nc_wide = CMP_W'(node_count);
      if (nc_wide == '0) begin
         used_n = CMP_W'(1);
      end else if (nc_wide > CMP_W'(NODES)) begin
         used_n = CMP_W'(NODES);
      end else begin
         used_n = nc_wide;
      end
   end

   // advance after each item, wrapping column then row
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (step) begin
         if (CMP_W'(cur_col) + CMP_W'(1) >= used_n) begin
            col_in = '0;
            if (CMP_W'(cur_row) + CMP_W'(1) >= used_n) begin
               row_in = '0;
            end else begin
               row_in = cur_row + PW'(1);
            end
         end else begin
            col_in = cur_col + PW'(1);
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/d2al_checker.sv @@
// ----------------------------------------------------------------------------
// d2al_checker
// Port-level checks of the adjacency list builder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dense_to_adjacency_list_defines.svh"

module d2al_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [d2al_pkg::NODE_W-1:0] rsp_node,
   input logic [d2al_pkg::SLOT_W-1:0] rsp_slot,
   input logic [d2al_pkg::NODE_W-1:0] rsp_neighbour,
   input logic                        rsp_overflow,
   input logic                        rsp_last
);
   import d2al_pkg::*;

   // a stalled result item holds
   `D2AL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_node) && $stable(rsp_slot) && $stable(rsp_neighbour) && $stable(rsp_last), "result changed while stalled")

   // an overflow is a lone, zeroed result
   `D2AL_ASSERT_IMP(a_ovf_form, clock, reset, rsp_valid && rsp_overflow, rsp_last && rsp_node == '0 && rsp_slot == '0 && rsp_neighbour == '0, "malformed overflow item")

   // the second append of a pair follows at once and mirrors the first
   `D2AL_ASSERT_NEXT(a_pair_mirror, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && !rsp_overflow && rsp_node == $past(rsp_neighbour) && rsp_neighbour == $past(rsp_node), "second append does not mirror the first")

   // reset drops any pending result
   `D2AL_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind dense_to_adjacency_list d2al_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_node      (rsp_node),
   .rsp_slot      (rsp_slot),
   .rsp_neighbour (rsp_neighbour),
   .rsp_overflow  (rsp_overflow),
   .rsp_last      (rsp_last)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dense matrix to adjacency list converter.
// ----------------------------------------------------------------------------
// Streams matrix weights row by row, keeps its own copy of the row and
// column position and of every neighbour count, and compares each list
// append or overflow coming out of the block with the predicted one.
// Threshold and node count are rewritten between runs of items while the
// block is idle. Both handshakes idle and stall at random, and once the
// output side stops for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import d2al_pkg::*;

   localparam int LIST_DEPTH    = MAX_NEIGHBOURS_DEF;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_PHASES    = 12;
   localparam int SWEEP_ROWS    = 10;
   localparam int MAX_PRINTS    = 40;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // node counts and matrix restarts of the random phases
   localparam int unsigned PHASE_NODES [RUN_PHASES] =
      '{1, 3, 0, 5, 127, 2, 8, 4, 100, 6, 16, 7};
   localparam bit PHASE_FRESH [RUN_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [SLOT_W-1:0] slot;
      logic [NODE_W-1:0] neighbour;
      logic              overflow;
      logic              last;
   } list_append_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                first;
   } matrix_item_type;

   // clock, reset and block ports
   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_ready;
   logic [WEIGHT_W-1:0]    req_weight          = '0;
   logic                   req_first_of_matrix = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready           = 1'b0;
   logic [NODE_W-1:0]      rsp_node;
   logic [SLOT_W-1:0]      rsp_slot;
   logic [NODE_W-1:0]      rsp_neighbour;
   logic                   rsp_overflow;
   logic                   rsp_last;
   logic                   csr_write_enable    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index           = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_write_data      = '0;

   // stimulus and expectation stores
   matrix_item_type weight_queue[$];
   list_append_type expected_appends[$];
   int unsigned  error_count = 0;
   bit           item_taken  = 1'b0;
   bit           gaps_on     = 1'b1;
   bit           hold_output = 1'b0;
   int unsigned  send_gap    = 0;
   int unsigned  stall_left  = 0;

   // shadow of the block: registers, position and list lengths
   logic [WEIGHT_W-1:0]     thr_cfg   = THRESHOLD_RESET;
   logic [NODE_COUNT_W-1:0] nodes_cfg = NODE_COUNT_RESET;
   int unsigned             cur_row   = 0;
   int unsigned             cur_col   = 0;
   int unsigned             list_len[NODES_DEF] = '{default: 0};

   dense_to_adjacency_list i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_weight          (req_weight),
      .req_first_of_matrix (req_first_of_matrix),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_node            (rsp_node),
      .rsp_slot            (rsp_slot),
      .rsp_neighbour       (rsp_neighbour),
      .rsp_overflow        (rsp_overflow),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #1 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("dense_to_adjacency_list verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   // out-of-range node counts clamp to 1 and to the node limit
   function automatic int unsigned nodes_in_use();
      if (nodes_cfg == 0) return 1;
      if (nodes_cfg > NODES_DEF) return NODES_DEF;
      return nodes_cfg;
   endfunction

   function automatic void add_append(input int unsigned node, input int unsigned slot,
                                      input int unsigned nb, input logic ovf,
                                      input logic fin);
      list_append_type a;
      a.node      = NODE_W'(node);
      a.slot      = SLOT_W'(slot);
      a.neighbour = NODE_W'(nb);
      a.overflow  = ovf;
      a.last      = fin;
      expected_appends.push_back(a);
   endfunction

   // appends caused by one weight, then advance the position
   function automatic void build_lists(input logic [WEIGHT_W-1:0] weight, input logic first);
      int unsigned row, col, len_r, len_c, n;
      if (first) begin
         foreach (list_len[i]) list_len[i] = 0;
         cur_row = 0;
         cur_col = 0;
      end
      row   = cur_row;
      col   = cur_col;
      len_r = list_len[row];
      len_c = list_len[col];
      if (weight >= thr_cfg && col <= row) begin
         if (col == row) begin
            // a self loop takes two slots of the same list
            if (len_r + 2 <= LIST_DEPTH) begin
               add_append(row, len_r, row, 1'b0, 1'b0);
               add_append(row, len_r + 1, row, 1'b0, 1'b1);
               list_len[row] = len_r + 2;
            end else begin
               add_append(0, 0, 0, 1'b1, 1'b1);
            end
         end else if (len_r < LIST_DEPTH && len_c < LIST_DEPTH) begin
            add_append(col, len_c, row, 1'b0, 1'b0);
            add_append(row, len_r, col, 1'b0, 1'b1);
            list_len[col] = len_c + 1;
            list_len[row] = len_r + 1;
         end else begin
            add_append(0, 0, 0, 1'b1, 1'b1);
         end
      end
      n = nodes_in_use();
      if (cur_col + 1 >= n) begin
         cur_col = 0;
         cur_row = (cur_row + 1 >= n) ? 0 : cur_row + 1;
      end else begin
         cur_col++;
      end
   endfunction

   // mostly no gap, sometimes a short one, rarely a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // input item driver
   always @(negedge clock) begin
      matrix_item_type nxt;
      if (!(req_valid && !item_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (weight_queue.size() > 0) begin
            nxt = weight_queue.pop_front();
            req_valid           <= 1'b1;
            req_weight          <= nxt.weight;
            req_first_of_matrix <= nxt.first;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      item_taken = 1'b0;
   end

   // result side back-pressure, with the long hold on request
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (hold_output) begin
         hold_output = 1'b0;
         stall_left  = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // predict on accepted weights, check accepted results
   always @(posedge clock) begin
      list_append_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            build_lists(req_weight, req_first_of_matrix);
            item_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_appends.size() == 0) begin
               report_mismatch($sformatf("unexpected result node %0d slot %0d ovf %0b",
                                         rsp_node, rsp_slot, rsp_overflow));
            end else begin
               want = expected_appends.pop_front();
               if (rsp_node !== want.node)
                  report_mismatch($sformatf("node %0d, expected %0d", rsp_node, want.node));
               if (rsp_slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d", rsp_slot, want.slot));
               if (rsp_neighbour !== want.neighbour)
                  report_mismatch($sformatf("neighbour %0d, expected %0d",
                                            rsp_neighbour, want.neighbour));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("overflow %0b, expected %0b",
                                            rsp_overflow, want.overflow));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
         end
      end
   end

   task automatic push_item(input logic [WEIGHT_W-1:0] weight, input logic first);
      matrix_item_type it;
      it.weight = weight;
      it.first  = first;
      weight_queue.push_back(it);
   endtask

   // register write, mirrored into the shadow copy
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_THRESHOLD) thr_cfg = data[WEIGHT_W-1:0];
      else nodes_cfg = data[NODE_COUNT_W-1:0];
   endtask

   // all items sent, all results seen, pipeline settled
   task automatic wait_drained();
      while (weight_queue.size() != 0 || req_valid || expected_appends.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // row-major matrices with random hits; noise flips the start-of-matrix flag
   task automatic push_matrix(input int unsigned count, input int unsigned hit_pct,
                              input int unsigned noise_pct, input bit fresh);
      int unsigned n, pos;
      matrix_item_type it;
      n   = nodes_in_use();
      pos = fresh ? 0 : 1;
      for (int unsigned i = 0; i < count; i++) begin
         it.first = (pos == 0);
         if ($urandom_range(0, 99) < noise_pct) it.first = ~it.first;
         if ($urandom_range(0, 99) < hit_pct) begin
            it.weight = ($urandom_range(0, 9) == 0)
                        ? thr_cfg
                        : WEIGHT_W'($urandom_range(thr_cfg, WEIGHT_MAX));
         end else if (thr_cfg == 0) begin
            it.weight = WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
         end else begin
            it.weight = ($urandom_range(0, 9) == 0)
                        ? thr_cfg - 17'd1
                        : WEIGHT_W'($urandom_range(0, thr_cfg - 17'd1));
         end
         weight_queue.push_back(it);
         pos = (pos + 1) % (n * n);
      end
   endtask

   // main sequence
   initial begin
      logic [WEIGHT_W-1:0] thr;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: self loop on node 0, extremes above the diagonal
      push_item(17'd1, 1'b1);
      push_item(WEIGHT_MAX, 1'b0);
      push_item('0, 1'b0);
      wait_drained();

      // two nodes at threshold one: boundary weights, filling lists to overflow
      write_csr(CSR_THRESHOLD, WEIGHT_ONE);
      write_csr(CSR_NODE_COUNT, 17'd2);
      for (int m = 0; m < 6; m++) begin
         push_item(WEIGHT_ONE, m == 0);
         push_item(WEIGHT_MAX, 1'b0);
         push_item((m == 0) ? WEIGHT_ONE - 17'd1 : WEIGHT_MAX, 1'b0);
         push_item(WEIGHT_ONE, 1'b0);
      end
      wait_drained();

      // the first rows of a sparse matrix at the full node count
      write_csr(CSR_NODE_COUNT, 17'd64);
      write_csr(CSR_THRESHOLD, 17'h08000);
      push_matrix(NODES_DEF * SWEEP_ROWS, 6, 0, 1'b1);
      wait_drained();

      // random settings, short runs of items, some continuing old positions
      for (int p = 0; p < RUN_PHASES; p++) begin
         case (p % 5)
            0: thr = '0;
            1: thr = WEIGHT_W'($urandom_range(1, WEIGHT_MAX));
            2: thr = WEIGHT_ONE;
            3: thr = WEIGHT_MAX;
            default: thr = 17'd1;
         endcase
         write_csr(CSR_THRESHOLD, thr);
         write_csr(CSR_NODE_COUNT, CSR_DATA_W'(PHASE_NODES[p]));
         gaps_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (p == 2) hold_output = 1'b1;
         push_matrix($urandom_range(30, 60), $urandom_range(30, 90), 3, PHASE_FRESH[p]);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("dense_to_adjacency_list verification clean");
      end else begin
         $display("dense_to_adjacency_list verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/d2al_pkg.sv
rtl/d2al_counts.sv
rtl/d2al_position.sv
rtl/dense_to_adjacency_list.sv
rtl/d2al_checker.sv
dv/tb_top.sv
